// File: rtl/brc_pkg.sv
`default_nettype none

package brc_pkg;

  // Width of sizes, surface dimensions and clip window registers.
  localparam int SIZE_BITS = 12;
  // Input coordinates carry one more bit than a size.
  localparam int CO_BITS = SIZE_BITS + 1;
  // Intermediate coordinates after the first clip.
  localparam int SPAN_BITS = SIZE_BITS + 2;
  // Output coordinates.
  localparam int OUT_BITS = SIZE_BITS + 3;
  // Signed working width used for the clipping comparisons and sums.
  localparam int WORK_BITS = SIZE_BITS + 4;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [SIZE_BITS-1:0] sz_t;
  typedef logic signed [CO_BITS-1:0] coord_t;
  typedef logic signed [SPAN_BITS-1:0] span_t;
  typedef logic signed [OUT_BITS-1:0] pos_t;
  typedef logic signed [WORK_BITS-1:0] wk_t;
  typedef logic [SIZE_BITS:0] shift_t;

  localparam wk_t WK_ONE = wk_t'(1);
  localparam wk_t WK_ZERO = wk_t'(0);
  localparam sz_t CLIP_SIZE_RESET = sz_t'(32'd4095);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } cfg_reg_t;

  // Destination clip window as held in the configuration registers.
  typedef struct packed {
    sz_t left;
    sz_t top;
    sz_t width;
    sz_t height;
  } brc_win_t;

endpackage

`default_nettype wire

// File: rtl/brc_cfg.sv
`default_nettype none

module brc_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [brc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  brc_pkg::sz_t                          cfg_data,
  output brc_pkg::brc_win_t                     win
);
  import brc_pkg::*;

  brc_win_t win_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg.left   <= '0;
      win_reg.top    <= '0;
      win_reg.width  <= CLIP_SIZE_RESET;
      win_reg.height <= CLIP_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLIP_LEFT:   win_reg.left   <= cfg_data;
        REG_CLIP_TOP:    win_reg.top    <= cfg_data;
        REG_CLIP_WIDTH:  win_reg.width  <= cfg_data;
        REG_CLIP_HEIGHT: win_reg.height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign win = win_reg;

endmodule

`default_nettype wire

// File: rtl/brc_axis.sv
`default_nettype none

// Three register stages of clipping along one axis: surface leading edge, then
// surface trailing edge and window leading edge, then window trailing edge.
module brc_axis (
  input  logic             clk,
  input  logic             en,
  input  logic             whole,
  input  brc_pkg::coord_t  src_pos,
  input  brc_pkg::sz_t     src_size,
  input  brc_pkg::sz_t     surf_size,
  input  brc_pkg::coord_t  dst_pos,
  input  brc_pkg::sz_t     win_lo,
  input  brc_pkg::sz_t     win_size,
  output brc_pkg::pos_t    src_pos_out,
  output brc_pkg::pos_t    dst_pos_out,
  output brc_pkg::sz_t     src_size_out,
  output brc_pkg::sz_t     dst_size_out
);
  import brc_pkg::*;

  // Stage 1 registers.
  sz_t    s1_sx;
  span_t  s1_rx2;
  span_t  s1_dx;
  sz_t    s1_dw;
  sz_t    s1_surf;
  // Stage 2 registers.
  sz_t    s2_sw;
  shift_t s2_dd;
  pos_t   s2_sx;
  span_t  s2_dx;
  pos_t   s2_drx2;
  // Stage 3 registers.
  pos_t   s3_sx;
  pos_t   s3_dx;
  sz_t    s3_sw;
  sz_t    s3_dw;

  wk_t a_sx, a_sw, a_dx, a_rx2, a_dd, a_sxc, a_dxc, a_dw;
  wk_t b_sx, b_rx2, b_bnd, b_rx2c, b_sw, b_dx, b_drx2, b_lo, b_dd, b_dxc, b_sxn;
  wk_t c_sw, c_dd, c_swn, c_cx2, c_drx2, c_drx2c, c_dx, c_dw;

  // Source rectangle selection and clip to the surface's left or top edge.
  always_comb begin
    a_sx  = whole ? WK_ZERO : {{(WORK_BITS-CO_BITS){src_pos[CO_BITS-1]}}, src_pos};
    a_sw  = whole ? {{(WORK_BITS-SIZE_BITS){1'b0}}, surf_size}
                  : {{(WORK_BITS-SIZE_BITS){1'b0}}, src_size};
    a_dx  = {{(WORK_BITS-CO_BITS){dst_pos[CO_BITS-1]}}, dst_pos};
    a_rx2 = a_sx + a_sw - WK_ONE;
    a_dd  = WK_ZERO - a_sx;
    if (a_sx[WORK_BITS-1]) begin
      a_sxc = WK_ZERO;
      a_dxc = a_dx + a_dd;
      a_dw  = (a_sw >= a_dd) ? a_sw - a_dd : WK_ZERO;
    end else begin
      a_sxc = a_sx;
      a_dxc = a_dx;
      a_dw  = a_sw;
    end
  end

  // Surface trailing edge, and the window's leading edge on the destination.
  always_comb begin
    b_sx   = {{(WORK_BITS-SIZE_BITS){1'b0}}, s1_sx};
    b_rx2  = {{(WORK_BITS-SPAN_BITS){s1_rx2[SPAN_BITS-1]}}, s1_rx2};
    b_bnd  = {{(WORK_BITS-SIZE_BITS){1'b0}}, s1_surf} - WK_ONE;
    b_rx2c = (b_rx2 > b_bnd) ? b_bnd : b_rx2;
    b_sw   = (b_sx > b_rx2c) ? WK_ZERO : b_rx2c - b_sx + WK_ONE;
    b_dx   = {{(WORK_BITS-SPAN_BITS){s1_dx[SPAN_BITS-1]}}, s1_dx};
    b_drx2 = b_dx + {{(WORK_BITS-SIZE_BITS){1'b0}}, s1_dw} - WK_ONE;
    b_lo   = {{(WORK_BITS-SIZE_BITS){1'b0}}, win_lo};
    if (b_dx < b_lo) begin
      b_dd  = b_lo - b_dx;
      b_dxc = b_lo;
    end else begin
      b_dd  = WK_ZERO;
      b_dxc = b_dx;
    end
    b_sxn = b_sx + b_dd;
  end

  // Source shrink by the window shift, and the window's trailing edge.
  always_comb begin
    c_sw    = {{(WORK_BITS-SIZE_BITS){1'b0}}, s2_sw};
    c_dd    = {{(WORK_BITS-SIZE_BITS-1){1'b0}}, s2_dd};
    c_swn   = (c_sw >= c_dd) ? c_sw - c_dd : WK_ZERO;
    c_cx2   = {{(WORK_BITS-SIZE_BITS){1'b0}}, win_lo}
            + {{(WORK_BITS-SIZE_BITS){1'b0}}, win_size} - WK_ONE;
    c_drx2  = {{(WORK_BITS-OUT_BITS){s2_drx2[OUT_BITS-1]}}, s2_drx2};
    c_drx2c = (c_drx2 > c_cx2) ? c_cx2 : c_drx2;
    c_dx    = {{(WORK_BITS-SPAN_BITS){s2_dx[SPAN_BITS-1]}}, s2_dx};
    c_dw    = (c_dx > c_drx2c) ? WK_ZERO : c_drx2c - c_dx + WK_ONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx   <= a_sxc[SIZE_BITS-1:0];
      s1_rx2  <= a_rx2[SPAN_BITS-1:0];
      s1_dx   <= a_dxc[SPAN_BITS-1:0];
      s1_dw   <= a_dw[SIZE_BITS-1:0];
      s1_surf <= surf_size;

      s2_sw   <= b_sw[SIZE_BITS-1:0];
      s2_dd   <= b_dd[SIZE_BITS:0];
      s2_sx   <= b_sxn[OUT_BITS-1:0];
      s2_dx   <= b_dxc[SPAN_BITS-1:0];
      s2_drx2 <= b_drx2[OUT_BITS-1:0];

      s3_sx   <= s2_sx;
      s3_dx   <= c_dx[OUT_BITS-1:0];
      s3_sw   <= c_swn[SIZE_BITS-1:0];
      s3_dw   <= c_dw[SIZE_BITS-1:0];
    end
  end

  assign src_pos_out  = s3_sx;
  assign dst_pos_out  = s3_dx;
  assign src_size_out = s3_sw;
  assign dst_size_out = s3_dw;

endmodule

`default_nettype wire

// File: rtl/blit_rectangle_clipper.sv
`default_nettype none

// Channel   | Direction | Handshake            | Contents
// ----------+-----------+----------------------+-----------------------------------
// input     | in        | in_valid / in_stall  | one blit request per transaction
// output    | out       | out_valid / out_stall| clipped origins, size, empty flag
// config    | in        | cfg_write            | clip window, index 0..3 on cfg_index
//
// Each request passes through the three clipping stages of each axis and then
// the output register that forms the copy size, and a new request can be taken
// in every cycle unless the input is stalled. Reset is synchronous and clears
// the valid bits and the clip window; data registers are not reset. A stalled
// result holds the whole pipeline, and the input is stalled only while a result
// waits at the output.
module blit_rectangle_clipper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [brc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  brc_pkg::sz_t                         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 whole_source,
  input  brc_pkg::coord_t                      src_left,
  input  brc_pkg::coord_t                      src_top,
  input  brc_pkg::sz_t                         src_width,
  input  brc_pkg::sz_t                         src_height,
  input  brc_pkg::sz_t                         surface_width,
  input  brc_pkg::sz_t                         surface_height,
  input  brc_pkg::coord_t                      dst_left,
  input  brc_pkg::coord_t                      dst_top,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output brc_pkg::pos_t                        out_src_left,
  output brc_pkg::pos_t                        out_src_top,
  output brc_pkg::pos_t                        out_dst_left,
  output brc_pkg::pos_t                        out_dst_top,
  output brc_pkg::sz_t                         out_width,
  output brc_pkg::sz_t                         out_height,
  output logic                                 empty_res
);
  import brc_pkg::*;

  brc_win_t win;

  // The pipeline advances as a whole unless a finished result is being held.
  logic en;
  logic v1, v2, v3;
  logic vout;

  pos_t x_src_pos, x_dst_pos, y_src_pos, y_dst_pos;
  sz_t  x_src_size, x_dst_size, y_src_size, y_dst_size;
  sz_t  w_next, h_next;

  pos_t r_src_left, r_src_top, r_dst_left, r_dst_top;
  sz_t  r_width, r_height;
  logic r_empty;

  assign en       = !(vout && out_stall);
  assign in_stall = vout && out_stall;

  brc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  // Horizontal and vertical clipping are independent of each other.
  brc_axis u_axis_x (
    .clk          (clk),
    .en           (en),
    .whole        (whole_source),
    .src_pos      (src_left),
    .src_size     (src_width),
    .surf_size    (surface_width),
    .dst_pos      (dst_left),
    .win_lo       (win.left),
    .win_size     (win.width),
    .src_pos_out  (x_src_pos),
    .dst_pos_out  (x_dst_pos),
    .src_size_out (x_src_size),
    .dst_size_out (x_dst_size)
  );

  brc_axis u_axis_y (
    .clk          (clk),
    .en           (en),
    .whole        (whole_source),
    .src_pos      (src_top),
    .src_size     (src_height),
    .surf_size    (surface_height),
    .dst_pos      (dst_top),
    .win_lo       (win.top),
    .win_size     (win.height),
    .src_pos_out  (y_src_pos),
    .dst_pos_out  (y_dst_pos),
    .src_size_out (y_src_size),
    .dst_size_out (y_dst_size)
  );

  // The copy size is the smaller of the clipped source and destination.
  assign w_next = (x_src_size < x_dst_size) ? x_src_size : x_dst_size;
  assign h_next = (y_src_size < y_dst_size) ? y_src_size : y_dst_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      vout <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_src_left <= x_src_pos;
      r_src_top  <= y_src_pos;
      r_dst_left <= x_dst_pos;
      r_dst_top  <= y_dst_pos;
      r_width    <= w_next;
      r_height   <= h_next;
      r_empty    <= (w_next == '0) || (h_next == '0);
    end
  end

  assign out_valid    = vout;
  assign out_src_left = r_src_left;
  assign out_src_top  = r_src_top;
  assign out_dst_left = r_dst_left;
  assign out_dst_top  = r_dst_top;
  assign out_width    = r_width;
  assign out_height   = r_height;
  assign empty_res    = r_empty;

  // An accepted transaction must occupy the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted transaction did not enter the pipeline");

  // The input is only held back while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A request in the last clipping stage reaches the output when not held.
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    (v3 && !in_stall) |=> out_valid)
    else $error("result lost between last stage and output");

  // Clipping to the surface leaves the source origin never negative.
  a_src_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_src_left[OUT_BITS-1] && !out_src_top[OUT_BITS-1]))
    else $error("clipped source origin is negative");

endmodule

`default_nettype wire
